// File: hdl/bnc_pkg.sv
// Shared types and constants for the bracket nesting checker.
// Used by every module of the block; no dependencies.

package bnc_pkg;

	// Stack geometry and count limits
	localparam int STACK_DEPTH = 256;
	localparam int LVL_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam int BANK_D = (STACK_DEPTH + 1) / 2;
	localparam int BANK_AW = (BANK_D > 1) ? $clog2(BANK_D) : 1;

	localparam longint MAX_TOKENS = 65535;
	localparam int CNT_W = $clog2(MAX_TOKENS + 1);
	localparam int POS_W = 17;
	localparam int SUM_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

	// Character bytes that matter
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LSQ    = 8'h5B;
	localparam logic [7:0] CH_RSQ    = 8'h5D;
	localparam logic [7:0] CH_LCUR   = 8'h7B;
	localparam logic [7:0] CH_RCUR   = 8'h7D;

	// Opener codes held on the stack
	typedef logic [2:0] kind_t;
	localparam kind_t K_PAREN  = 3'd0;
	localparam kind_t K_SQUARE = 3'd1;
	localparam kind_t K_CURLY  = 3'd2;
	localparam kind_t K_ANGLE  = 3'd3;
	localparam kind_t K_PSTAR  = 3'd4;

	// Lookahead codes
	typedef logic [1:0] pend_t;
	localparam pend_t P_NONE  = 2'd0;
	localparam pend_t P_PAREN = 2'd1;
	localparam pend_t P_STAR  = 2'd2;

	// Per-line state; top mirrors the stack entry at level-1
	typedef struct packed {
		logic [LVL_W-1:0] level;
		pend_t            pend;
		logic [CNT_W-1:0] count;
		logic             failed;
		logic [CNT_W-1:0] fail_pos;
		logic             ovf;
		kind_t            top;
	} line_t;

	// Up to two pushes per item, at consecutive indexes
	typedef struct packed {
		logic             en0;
		logic [IDX_W-1:0] idx0;
		kind_t            code0;
		logic             en1;
		logic [IDX_W-1:0] idx1;
		kind_t            code1;
	} stk_wr_t;

endpackage

// File: hdl/bnc_stack.sv
// Opener stack storage: two banks (even/odd index), one write and one
// registered read each per cycle, with same-cycle write forwarding. Uses bnc_pkg.

module bnc_stack (
	input  logic                    clk,
	input  bnc_pkg::stk_wr_t        wr,
	input  logic [bnc_pkg::IDX_W-1:0] rd_idx,
	output bnc_pkg::kind_t          sec
);
	import bnc_pkg::*;

	kind_t bank_rd_q [2];
	logic  sel_q;
	logic  fwd_q;
	kind_t fwd_code_q;

	function automatic logic [BANK_AW-1:0] f_baddr(input logic [IDX_W-1:0] i);
		return BANK_AW'(i >> 1);
	endfunction

	for (genvar b = 0; b < 2; b++) begin : g_bank
		kind_t                mem [BANK_D];
		logic                 we;
		logic [BANK_AW-1:0]   wa;
		kind_t                wd;

		always_comb begin
			priority if (wr.en0 && (wr.idx0[0] == 1'(b))) begin
				we = 1'b1;
				wa = f_baddr(wr.idx0);
				wd = wr.code0;
			end else if (wr.en1 && (wr.idx1[0] == 1'(b))) begin
				we = 1'b1;
				wa = f_baddr(wr.idx1);
				wd = wr.code1;
			end else begin
				we = 1'b0;
				wa = f_baddr(wr.idx0);
				wd = wr.code0;
			end
		end

		always_ff @(posedge clk) begin
			if (we) begin
				mem[wa] <= wd;
			end
			bank_rd_q[b] <= mem[f_baddr(rd_idx)];
		end
	end

	// forward an entry written in the same cycle it is read
	always_ff @(posedge clk) begin
		sel_q <= rd_idx[0];
		if (wr.en1 && (wr.idx1 == rd_idx)) begin
			fwd_q      <= 1'b1;
			fwd_code_q <= wr.code1;
		end else if (wr.en0 && (wr.idx0 == rd_idx)) begin
			fwd_q      <= 1'b1;
			fwd_code_q <= wr.code0;
		end else begin
			fwd_q      <= 1'b0;
			fwd_code_q <= wr.code0;
		end
	end

	assign sec = fwd_q ? fwd_code_q : bank_rd_q[sel_q];

endmodule

// File: hdl/bnc_step.sv
// Token logic for one character: lookahead, push/pop, counting, end-of-line
// result. Purely combinational. Uses bnc_pkg.

module bnc_step (
	input  bnc_pkg::line_t             st,
	input  bnc_pkg::kind_t             sec,
	input  logic [7:0]                 ch,
	input  logic                       has,
	input  logic                       eol,
	input  logic                       go,
	output bnc_pkg::line_t             nx,
	output bnc_pkg::stk_wr_t           wr,
	output logic                       res_balanced,
	output logic [bnc_pkg::POS_W-1:0]  res_pos,
	output logic                       res_ovf
);
	import bnc_pkg::*;

	typedef struct packed {
		line_t   ln;
		kind_t   below;
		stk_wr_t wr;
	} wk_t;

	function automatic wk_t f_bump(input wk_t w);
		if (w.ln.count != CNT_W'(MAX_TOKENS)) begin
			w.ln.count = w.ln.count + CNT_W'(1);
		end
		return w;
	endfunction

	function automatic wk_t f_fail(input wk_t w);
		w.ln.failed   = 1'b1;
		w.ln.fail_pos = w.ln.count;
		w.ln.pend     = P_NONE;
		return w;
	endfunction

	function automatic wk_t f_open(input wk_t w, input kind_t code, input logic keep);
		w = f_bump(w);
		if (w.ln.level == LVL_W'(STACK_DEPTH)) begin
			w.ln.ovf = 1'b1;
			w = f_fail(w);
		end else begin
			if (keep) begin
				if (!w.wr.en0) begin
					w.wr.en0   = 1'b1;
					w.wr.idx0  = IDX_W'(w.ln.level);
					w.wr.code0 = code;
				end else begin
					w.wr.en1   = 1'b1;
					w.wr.idx1  = IDX_W'(w.ln.level);
					w.wr.code1 = code;
				end
			end
			w.below    = w.ln.top;
			w.ln.top   = code;
			w.ln.level = w.ln.level + LVL_W'(1);
		end
		return w;
	endfunction

	function automatic wk_t f_close(input wk_t w, input kind_t code);
		w = f_bump(w);
		if ((w.ln.level == '0) || (w.ln.top != code)) begin
			w = f_fail(w);
		end else begin
			w.ln.level = w.ln.level - LVL_W'(1);
			w.ln.top   = w.below;
		end
		return w;
	endfunction

	function automatic wk_t f_plain(input wk_t w, input logic [7:0] c);
		unique case (c)
			CH_LPAREN: w.ln.pend = P_PAREN;
			CH_STAR:   w.ln.pend = P_STAR;
			CH_LSQ:    w = f_open(w, K_SQUARE, 1'b1);
			CH_LCUR:   w = f_open(w, K_CURLY, 1'b1);
			CH_LT:     w = f_open(w, K_ANGLE, 1'b1);
			CH_RPAREN: w = f_close(w, K_PAREN);
			CH_RSQ:    w = f_close(w, K_SQUARE);
			CH_RCUR:   w = f_close(w, K_CURLY);
			CH_GT:     w = f_close(w, K_ANGLE);
			default:   w = f_bump(w);
		endcase
		return w;
	endfunction

	function automatic wk_t f_feed(input wk_t w, input logic [7:0] c);
		if (w.ln.pend == P_PAREN) begin
			w.ln.pend = P_NONE;
			if (c == CH_STAR) begin
				return f_open(w, K_PSTAR, 1'b1);
			end
			w = f_open(w, K_PAREN, 1'b1);
			if (w.ln.failed) begin
				return w;
			end
		end else if (w.ln.pend == P_STAR) begin
			w.ln.pend = P_NONE;
			if (c == CH_RPAREN) begin
				return f_close(w, K_PSTAR);
			end
			w = f_bump(w);
		end else begin
			w.ln.pend = P_NONE;
		end
		return f_plain(w, c);
	endfunction

	// held lookahead at end of line; the stack itself is dropped, so no write
	function automatic wk_t f_flush(input wk_t w);
		if (w.ln.pend == P_PAREN) begin
			w.ln.pend = P_NONE;
			w = f_open(w, K_PAREN, 1'b0);
		end else if (w.ln.pend == P_STAR) begin
			w.ln.pend = P_NONE;
			w = f_bump(w);
		end
		return w;
	endfunction

	wk_t              w;
	logic [SUM_W-1:0] open_pos;
	logic [SUM_W-1:0] fail_pos;

	always_comb begin
		w.ln    = st;
		w.below = sec;
		w.wr    = '0;
		if (go && has && !st.failed) begin
			w = f_feed(w, ch);
		end
		if (go && eol && !w.ln.failed) begin
			w = f_flush(w);
		end

		open_pos = SUM_W'(w.ln.count) + SUM_W'(1);
		fail_pos = SUM_W'(w.ln.fail_pos);

		res_balanced = !w.ln.failed && (w.ln.level == '0);
		res_ovf      = w.ln.ovf;
		priority if (res_balanced) begin
			res_pos = '0;
		end else if (w.ln.failed) begin
			res_pos = fail_pos[POS_W-1:0];
		end else begin
			res_pos = open_pos[POS_W-1:0];
		end

		nx = (go && eol) ? line_t'('0) : w.ln;
		wr = w.wr;
	end

endmodule

// File: hdl/bracket_nesting_checker_core.sv
// Bracket nesting checker, top level. Depends on bnc_pkg, bnc_step, bnc_stack.
// Takes one character per transfer and checks the line for proper nesting.
//
// A line arrives as a run of input transfers (ch, has_char, end_of_line); the
// transfer with end_of_line set closes the line and produces exactly one result
// transfer (balanced, error_position, overflow). Other transfers produce none.
// Throughput is one character per clock: each character is captured in an
// input register, then the token logic updates the line state and, at end of
// line, loads the result register; balanced, error_position and overflow are
// driven straight from that register. The per-character cost is
// one top-of-stack compare plus up to two pushes or one pop; the top entry is
// kept in a register, and the entry below it comes from the registered read of
// a two-bank stack memory (even/odd index), so pushes of "(" followed by an
// opener land in different banks in the same cycle. The only stall: an
// end-of-line transfer held in the input register while the previous result
// still waits for result_ready. Nesting deeper than STACK_DEPTH (256) fails the
// line with overflow set; the token count saturates at 65535. The stack needs
// no clearing after reset or between lines.

module bracket_nesting_checker_core (
	input  logic                      clk,
	input  logic                      arst_n,
	// character channel
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic [7:0]                ch,
	input  logic                      has_char,
	input  logic                      end_of_line,
	// result channel
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic                      balanced,
	output logic [bnc_pkg::POS_W-1:0] error_position,
	output logic                      overflow
);
	import bnc_pkg::*;

	// input register
	logic       v_s1;
	logic [7:0] ch_s1;
	logic       has_s1;
	logic       eol_s1;

	// line state and result register
	line_t            line_q;
	line_t            line_nx;
	logic             res_valid_q;
	logic             balanced_q;
	logic [POS_W-1:0] pos_q;
	logic             ovf_q;

	stk_wr_t          wr;
	kind_t            sec;
	logic             go;
	logic             res_balanced;
	logic [POS_W-1:0] res_pos;
	logic             res_ovf;
	logic [IDX_W-1:0] rd_idx;

	// The captured character is processed unless it closes a line and the
	// result slot is still occupied.
	assign go         = v_s1 && (!eol_s1 || !res_valid_q || result_ready);
	assign item_ready = !v_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			v_s1 <= 1'b1;
		end else if (go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			ch_s1  <= ch;
			has_s1 <= has_char;
			eol_s1 <= end_of_line;
		end
	end

	bnc_step u_step (
		.st           (line_q),
		.sec          (sec),
		.ch           (ch_s1),
		.has          (has_s1),
		.eol          (eol_s1),
		.go           (go),
		.nx           (line_nx),
		.wr           (wr),
		.res_balanced (res_balanced),
		.res_pos      (res_pos),
		.res_ovf      (res_ovf)
	);

	// Entry under the new top: read it now so it is ready next cycle.
	assign rd_idx = IDX_W'(line_nx.level - LVL_W'(2));

	bnc_stack u_stack (
		.clk    (clk),
		.wr     (wr),
		.rd_idx (rd_idx),
		.sec    (sec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
		end else begin
			line_q <= line_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go && eol_s1) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && eol_s1) begin
			balanced_q <= res_balanced;
			pos_q      <= res_pos;
			ovf_q      <= res_ovf;
		end
	end

	assign result_valid   = res_valid_q;
	assign balanced       = balanced_q;
	assign error_position = pos_q;
	assign overflow       = ovf_q;

endmodule

// File: hdl/bnc_checker.sv
// Port-level assertions for the bracket nesting checker and the bind that
// attaches them to bracket_nesting_checker_core. Uses bnc_pkg.

module bnc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      item_valid,
	input logic                      item_ready,
	input logic [7:0]                ch,
	input logic                      has_char,
	input logic                      end_of_line,
	input logic                      result_valid,
	input logic                      result_ready,
	input logic                      balanced,
	input logic [bnc_pkg::POS_W-1:0] error_position,
	input logic                      overflow
);
	import bnc_pkg::*;

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(balanced)
			&& $stable(error_position) && $stable(overflow))
		else $error("result changed while stalled");

	// a balanced line has no error position and no overflow
	a_bal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && balanced |-> (error_position == '0) && !overflow)
		else $error("balanced result with error data");

	// every failure points at a token, positions start at one
	a_fail_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !balanced |-> error_position != '0)
		else $error("unbalanced result with zero position");

	// overflow needs more openers than the stack holds
	a_ovf_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && overflow |-> error_position > POS_W'(STACK_DEPTH))
		else $error("overflow reported too early in the line");

endmodule

bind bracket_nesting_checker_core bnc_checker u_bnc_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for bracket_nesting_checker_core.
// Streams lines of characters through the block and checks every verdict against a
// nesting predictor built on bnc_pkg types; needs only the block's RTL.
`timescale 1ns / 1ps

module tb;
	import bnc_pkg::*;

	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int ITEM_TARGET  = 1850;  // characters and line ends in the whole run
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLDOFF_LEN  = 600;   // long receiver stall, fills the block
	localparam int HOLDOFF_AT   = 20;    // verdict count at which it starts

	typedef struct packed {
		logic [7:0] code;
		logic       has;
		logic       eol;
	} char_item_t;

	typedef struct packed {
		logic             balanced;
		logic [POS_W-1:0] pos;
		logic             ovf;
	} verdict_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_ready;
	logic [7:0]       ch = 8'h00;
	logic             has_char = 1'b0;
	logic             end_of_line = 1'b0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	logic             balanced;
	logic [POS_W-1:0] error_position;
	logic             overflow;

	bracket_nesting_checker_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.ch             (ch),
		.has_char       (has_char),
		.end_of_line    (end_of_line),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.balanced       (balanced),
		.error_position (error_position),
		.overflow       (overflow)
	);

	always #4 clk = ~clk;

	char_item_t  char_queue[$];     // characters not yet offered to the block
	verdict_t    verdict_queue[$];  // verdicts owed for lines already closed
	logic [7:0]  line_buf[$];       // text of the line being generated
	int unsigned shaped_items = 0;  // characters and line ends queued so far
	int unsigned stim_total = 0;
	int unsigned chars_accepted = 0;
	int unsigned results_seen = 0;
	int unsigned fail_cnt = 0;
	int unsigned cycle_cnt = 0;

	logic [7:0] bracket_set[9] = '{CH_LPAREN, CH_RPAREN, CH_STAR, CH_LT, CH_GT,
		CH_LSQ, CH_RSQ, CH_LCUR, CH_RCUR};

	// ------------------------------------------------------------------
	// Nesting predictor: per-line state, same depth and count limits as the block
	// ------------------------------------------------------------------
	kind_t       nest_stack[STACK_DEPTH];
	int unsigned nest_level = 0;
	pend_t       held = P_NONE;     // '(' or '*' waiting for the next char
	int unsigned tok_cnt = 0;
	bit          line_bad = 1'b0;
	int unsigned bad_pos = 0;
	bit          line_ovf = 1'b0;

	// token count stops at MAX_TOKENS
	function automatic void count_token();
		if (tok_cnt < MAX_TOKENS)
			tok_cnt++;
	endfunction

	function automatic void mark_bad();
		line_bad = 1'b1;
		bad_pos = tok_cnt;
		held = P_NONE;
	endfunction

	function automatic void nest_open(kind_t k);
		count_token();
		if (nest_level >= STACK_DEPTH) begin
			line_ovf = 1'b1;
			mark_bad();
		end else begin
			nest_stack[nest_level] = k;
			nest_level++;
		end
	endfunction

	// level is checked first, so only entries written on this line are read
	function automatic void nest_close(kind_t k);
		count_token();
		if (nest_level == 0 || nest_stack[nest_level-1] != k)
			mark_bad();
		else
			nest_level--;
	endfunction

	function automatic void feed_char(logic [7:0] c);
		// resolve the lookahead first: "(*" and "*)" are single tokens
		if (held == P_PAREN) begin
			held = P_NONE;
			if (c == CH_STAR) begin
				nest_open(K_PSTAR);
				return;
			end
			nest_open(K_PAREN);
			if (line_bad)
				return;
		end else if (held == P_STAR) begin
			held = P_NONE;
			if (c == CH_RPAREN) begin
				nest_close(K_PSTAR);
				return;
			end
			count_token();
		end
		case (c)
			CH_LPAREN: held = P_PAREN;
			CH_STAR:   held = P_STAR;
			CH_LSQ:    nest_open(K_SQUARE);
			CH_LCUR:   nest_open(K_CURLY);
			CH_LT:     nest_open(K_ANGLE);
			CH_RPAREN: nest_close(K_PAREN);
			CH_RSQ:    nest_close(K_SQUARE);
			CH_RCUR:   nest_close(K_CURLY);
			CH_GT:     nest_close(K_ANGLE);
			default:   count_token();
		endcase
	endfunction

	// one accepted transfer; a line end owes one verdict
	function automatic void predict_char(logic [7:0] c, logic has, logic eol);
		verdict_t v;
		if (has && !line_bad)
			feed_char(c);
		if (eol) begin
			// a held '(' still opens, a held '*' is a plain token
			if (!line_bad) begin
				if (held == P_PAREN)
					nest_open(K_PAREN);
				else if (held == P_STAR)
					count_token();
				held = P_NONE;
			end
			v.balanced = !line_bad && nest_level == 0;
			if (v.balanced)
				v.pos = '0;
			else if (line_bad)
				v.pos = POS_W'(bad_pos);
			else
				v.pos = POS_W'(tok_cnt + 1);
			v.ovf = line_ovf;
			verdict_queue.push_back(v);
			nest_level = 0;
			held = P_NONE;
			tok_cnt = 0;
			line_bad = 1'b0;
			bad_pos = 0;
			line_ovf = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus shaping
	// ------------------------------------------------------------------
	function automatic void put(logic [7:0] c, logic has, logic eol);
		char_item_t it;
		it.code = c;
		it.has = has;
		it.eol = eol;
		char_queue.push_back(it);
		if (has || eol)
			shaped_items++;
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i], 1'b1, i == s.len() - 1);
	endfunction

	function automatic logic [7:0] pick_bracket();
		return bracket_set[$urandom_range(0, 8)];
	endfunction

	function automatic void write_closer(kind_t k);
		case (k)
			K_PAREN:  line_buf.push_back(CH_RPAREN);
			K_SQUARE: line_buf.push_back(CH_RSQ);
			K_CURLY:  line_buf.push_back(CH_RCUR);
			K_ANGLE:  line_buf.push_back(CH_GT);
			default: begin
				line_buf.push_back(CH_STAR);
				line_buf.push_back(CH_RPAREN);
			end
		endcase
	endfunction

	// properly nested text with filler letters between tokens
	function automatic void build_nested(int unsigned cap, int unsigned steps,
		int unsigned open_pct);
		kind_t opened[$];
		kind_t k;
		repeat (steps) begin
			if (opened.size() < cap &&
				(opened.size() == 0 || $urandom_range(0, 99) < open_pct)) begin
				k = kind_t'($urandom_range(0, 4));
				opened.push_back(k);
				case (k)
					K_PAREN:  line_buf.push_back(CH_LPAREN);
					K_SQUARE: line_buf.push_back(CH_LSQ);
					K_CURLY:  line_buf.push_back(CH_LCUR);
					K_ANGLE:  line_buf.push_back(CH_LT);
					default: begin
						line_buf.push_back(CH_LPAREN);
						line_buf.push_back(CH_STAR);
					end
				endcase
			end else begin
				write_closer(opened.pop_back());
			end
			if ($urandom_range(0, 3) == 0)
				line_buf.push_back(8'h61 + 8'($urandom_range(0, 25)));  // 'a'..'z'
		end
		// now and then the line is left open
		if ($urandom_range(0, 7) != 0)
			while (opened.size() != 0)
				write_closer(opened.pop_back());
	endfunction

	// line_buf out as transfers, with idle no-char items mixed in
	function automatic void emit_line(bit bare_end);
		foreach (line_buf[i]) begin
			if ($urandom_range(0, 15) == 0)
				put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			put(line_buf[i], 1'b1, !bare_end && i == line_buf.size() - 1);
		end
		if (bare_end || line_buf.size() == 0)
			put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endfunction

	task automatic build_stimulus();
		int unsigned sel;
		int unsigned cap;
		bit deep;

		// directed: lookahead forms, bare items, early failure
		put(8'hFF, 1'b0, 1'b0);   // no char, no line end: ignored
		put(8'h00, 1'b0, 1'b1);   // empty line
		put_text("(*[]*)");       // pair tokens nest around a square pair
		put_text("(*)");          // "(*" closed by ')' fails
		put_text("{<>}(");        // held '(' opens at line end
		put_text("[*");           // held '*' is a plain token at line end
		put_text("](");           // fails at once, rest ignored
		put_text("((*");          // '(' then "(*"

		// stack depth: exactly full, overflow by char, overflow by held '('
		repeat (STACK_DEPTH) put(CH_LT, 1'b1, 1'b0);
		repeat (STACK_DEPTH - 1) put(CH_GT, 1'b1, 1'b0);
		put(CH_GT, 1'b1, 1'b1);
		repeat (STACK_DEPTH) put(CH_LSQ, 1'b1, 1'b0);
		put(CH_LT, 1'b1, 1'b1);
		repeat (STACK_DEPTH) put(CH_LCUR, 1'b1, 1'b0);
		put(CH_LPAREN, 1'b1, 1'b1);

		// random lines, mostly well nested so the stack gets exercised
		while (shaped_items < ITEM_TARGET) begin
			line_buf.delete();
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				deep = ($urandom_range(0, 99) == 0);
				cap = deep ? $urandom_range(240, 300) : $urandom_range(1, 12);
				build_nested(cap, deep ? cap + 20 : $urandom_range(1, 24), deep ? 95 : 55);
				if (line_buf.size() != 0 && $urandom_range(0, 3) == 0) begin
					cap = $urandom_range(0, line_buf.size() - 1);
					case ($urandom_range(0, 2))
						0: line_buf[cap] = pick_bracket();
						1: line_buf[cap] = 8'($urandom_range(0, 255));
						default: line_buf.delete(cap);
					endcase
				end
			end else if (sel < 85) begin
				repeat ($urandom_range(1, 20)) line_buf.push_back(pick_bracket());
			end else begin
				repeat ($urandom_range(0, 10))
					line_buf.push_back(8'($urandom_range(0, 255)));
			end
			emit_line($urandom_range(0, 7) == 0);
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of transfers separated by random gaps
	// ------------------------------------------------------------------
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk or negedge arst_n) begin : drive
		char_item_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
			ch <= 8'h00;
			has_char <= 1'b0;
			end_of_line <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!item_valid || item_ready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				item_valid <= 1'b0;
			end else if (char_queue.size() != 0) begin
				nxt = char_queue.pop_front();
				ch <= nxt.code;
				has_char <= nxt.has;
				end_of_line <= nxt.eol;
				item_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: rotating stall pattern plus one long hold-off
	// ------------------------------------------------------------------
	int unsigned holdoff_left = 0;
	bit          holdoff_done = 1'b0;
	logic [7:0]  stall_phase = '0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			holdoff_left <= 0;
			holdoff_done <= 1'b0;
			stall_phase <= '0;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
			result_ready <= 1'b0;
		end else if (!holdoff_done && results_seen == HOLDOFF_AT) begin
			// sender keeps going; a second line end must back up the input
			holdoff_left <= HOLDOFF_LEN;
			holdoff_done <= 1'b1;
			result_ready <= 1'b0;
		end else begin
			stall_phase <= stall_phase + 8'd1;
			case (stall_phase[7:6])
				2'd0, 2'd1: result_ready <= 1'b1;
				2'd2:       result_ready <= 1'($urandom_range(0, 1));
				default:    result_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check verdicts, then predict from the accepted character
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		verdict_t v;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				results_seen <= results_seen + 1;
				if (verdict_queue.size() == 0) begin
					$error("verdict transfer with no line pending");
					fail_cnt++;
				end else begin
					v = verdict_queue.pop_front();
					if (balanced !== v.balanced) begin
						$error("balanced: expected %0d, got %0d", v.balanced, balanced);
						fail_cnt++;
					end
					if (error_position !== v.pos) begin
						$error("error_position: expected %0d, got %0d", v.pos, error_position);
						fail_cnt++;
					end
					if (overflow !== v.ovf) begin
						$error("overflow: expected %0d, got %0d", v.ovf, overflow);
						fail_cnt++;
					end
				end
			end
			if (item_valid && item_ready) begin
				chars_accepted <= chars_accepted + 1;
				predict_char(ch, has_char, end_of_line);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		build_stimulus();
		stim_total = char_queue.size();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (chars_accepted != stim_total) @(negedge clk);
		while (verdict_queue.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
